### rtl/core/pvl_pkg.sv
// ----------------------------------------------------------------------------
// pvl_pkg: shared types and constants of the polyphony voice limiter
// Field widths of a request and of a stored voice entry, plus the register map.
// ----------------------------------------------------------------------------
package pvl_pkg;

  localparam int TagW   = 16;
  localparam int TickW  = 32;
  localparam int VelW   = 7;
  localparam int PitchW = 7;
  localparam int RankW  = VelW + TickW + PitchW;
  localparam int LimW   = 5;
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  // Word index of the only register.
  localparam logic REG_MAX_VOICES = 1'b0;

  typedef logic [TagW-1:0]   tag_t;
  typedef logic [TickW-1:0]  tick_t;
  typedef logic [VelW-1:0]   vel_t;
  typedef logic [PitchW-1:0] pitch_t;
  typedef logic [RankW-1:0]  rank_t;
  typedef logic [LimW-1:0]   lim_t;
  typedef logic [PaddrW-1:0] paddr_t;
  typedef logic [PdataW-1:0] pdata_t;

  typedef struct packed {
    tag_t  tag;
    tick_t end_tick;
    rank_t rank;
  } voice_t;

endpackage

### rtl/core/polyphony_voice_limiter.sv
// ----------------------------------------------------------------------------
// polyphony_voice_limiter: voice-stealing polyphony limiter
// Keeps a list of sounding voices and decides per note whether it
// gets a voice, steals the weakest one, or is rejected.
// ----------------------------------------------------------------------------
// Usage: note requests enter on the input channel (in_valid_i / in_stall_o)
// and one verdict per note leaves on the output channel (out_valid_o /
// out_stall_i). A request is taken when valid is high and stall is low.
// The voice limit is written through the APB port; write it only while the
// block is idle. A limit of zero means unlimited: every note is accepted and
// no voice is stored.
// A note runs one pass over the voice memory, one entry a cycle through its
// registered read port, that drops expired voices and finds the weakest
// remaining one at the same time; after a restart the pass begins with no
// voice held. The decision state then decides and writes the new voice. The
// input is free again in the same cycle that the verdict appears, and the
// block takes one note at a time.
// Reset empties the voice list and sets the limit to zero. A stalled verdict
// stays in the output register; the next note may already be taken and runs
// its pass, and its decision waits until the output register is free.
// ----------------------------------------------------------------------------
module polyphony_voice_limiter #(
  parameter int MAX_VOICES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // APB configuration port
  input  logic            psel_i,
  input  logic            penable_i,
  input  logic            pwrite_i,
  input  pvl_pkg::paddr_t paddr_i,
  input  pvl_pkg::pdata_t pwdata_i,
  output pvl_pkg::pdata_t prdata_o,
  output logic            pready_o,
  // Note requests
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pvl_pkg::tag_t   note_id_i,
  input  pvl_pkg::tick_t  start_tick_i,
  input  pvl_pkg::tick_t  end_tick_i,
  input  pvl_pkg::vel_t   velocity_i,
  input  pvl_pkg::pitch_t pitch_i,
  input  logic            restart_i,
  // Verdicts
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            accepted_o,
  output logic            evicted_o,
  output pvl_pkg::tag_t   evicted_id_o,
  output pvl_pkg::lim_t   voices_active_o
);
  import pvl_pkg::*;

  // Index width of the voice memory, and a count width that can hold the
  // full depth.
  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  // Width wide enough to compare a count against the register value.
  localparam int LW = (CW > LimW) ? CW : LimW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e          state_q;
  lim_t            max_voices_q;
  logic [CW-1:0]   cnt_q;

  // Latched request and its priority rank.
  tag_t            tag_q;
  tick_t           start_q;
  tick_t           end_q;
  rank_t           rank_q;

  // Scan pass bookkeeping.
  logic [CW-1:0]   rd_cnt_q;
  logic            rd_vld_q;
  logic [CW-1:0]   keep_q;
  logic            have_min_q;
  rank_t           min_rank_q;
  logic [IW-1:0]   weak_q;
  tag_t            weak_tag_q;

  // Voice memory with a registered read port.
  voice_t          mem_q [MAX_VOICES];
  voice_t          rd_entry_q;

  // Output register.
  logic            out_valid_q;
  logic            accepted_q;
  logic            evicted_q;
  tag_t            evicted_id_q;
  lim_t            voices_active_q;

  // Combinational signals.
  logic            cfg_wr;
  logic            out_free;
  logic            keep_hit;
  logic [LW-1:0]   limit;
  logic [LW-1:0]   cnt_ext;
  tick_t           dur;
  rank_t           new_rank;
  rank_t           cmp_a;
  rank_t           cmp_b;
  logic            cmp_lt;
  logic            dec_append;
  logic            dec_steal;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  voice_t          wr_data;
  logic [IW-1:0]   rd_addr;

  // -------------------------------------------------------------------------
  // Configuration port. Only the word index is decoded.
  // -------------------------------------------------------------------------
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_MAX_VOICES);
  assign prdata_o = (paddr_i[2] == REG_MAX_VOICES) ? PdataW'(max_voices_q) : '0;

  // -------------------------------------------------------------------------
  // Datapath
  // -------------------------------------------------------------------------
  // Rank orders notes by velocity, then duration, then pitch. A note whose
  // end is not after its start counts as zero length.
  assign dur      = (end_tick_i > start_tick_i) ? (end_tick_i - start_tick_i) : '0;
  assign new_rank = {velocity_i, dur, pitch_i};

  // The limit saturates at the memory depth.
  assign limit   = (LW'(max_voices_q) > LW'(MAX_VOICES)) ? LW'(MAX_VOICES)
                                                         : LW'(max_voices_q);
  assign cnt_ext = LW'(cnt_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign keep_hit = rd_entry_q.end_tick > start_q;
  assign rd_addr  = rd_cnt_q[IW-1:0];

  // One rank comparator serves both the minimum search and the final steal
  // test: during the scan it asks whether an entry is weaker than the current
  // minimum, in the decision cycle whether the minimum is weaker than the
  // new note.
  always_comb begin
    if (state_q == ST_SCAN) begin
      cmp_a = rd_entry_q.rank;
      cmp_b = min_rank_q;
    end else begin
      cmp_a = min_rank_q;
      cmp_b = rank_q;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Decision of the final cycle: append while there is room, otherwise steal
  // when the new note is strictly stronger than the weakest voice.
  assign dec_append = (limit != '0) && (cnt_ext < limit);
  assign dec_steal  = (limit != '0) && !(cnt_ext < limit) && (cnt_q != '0) && cmp_lt;

  // Memory write selection: compaction writes during the scan, and the new
  // voice in the decision cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '{tag: tag_q, end_tick: end_q, rank: rank_q};
    case (state_q)
      ST_SCAN: begin
        if (rd_vld_q && keep_hit) begin
          wr_en   = 1'b1;
          wr_addr = keep_q[IW-1:0];
          wr_data = rd_entry_q;
        end
      end
      ST_DECIDE: begin
        if (out_free && dec_append) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[IW-1:0];
        end else if (out_free && dec_steal) begin
          wr_en   = 1'b1;
          wr_addr = weak_q;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Compaction writes only to entries already read, so the write and the
  // read of one cycle never touch the same entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_entry_q <= mem_q[rd_addr];
  end

  // -------------------------------------------------------------------------
  // Sequencer and registered outputs
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_voices_q <= '0;
      cnt_q        <= '0;
      rd_cnt_q     <= '0;
      rd_vld_q     <= 1'b0;
      keep_q       <= '0;
      have_min_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_voices_q <= pwdata_i[LimW-1:0];
      end
      // A new verdict may replace one that is taken in the same cycle.
      if ((state_q == ST_DECIDE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            tag_q      <= note_id_i;
            start_q    <= start_tick_i;
            end_q      <= end_tick_i;
            rank_q     <= new_rank;
            rd_cnt_q   <= '0;
            rd_vld_q   <= 1'b0;
            keep_q     <= '0;
            have_min_q <= 1'b0;
            if (restart_i) begin
              cnt_q <= '0;
            end
            state_q <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Issue one read a cycle while entries remain.
          rd_vld_q <= rd_cnt_q < cnt_q;
          if (rd_cnt_q < cnt_q) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          // A surviving voice moves down to its new place; the first of the
          // weakest survivors is remembered under that new place.
          if (rd_vld_q && keep_hit) begin
            keep_q <= keep_q + 1'b1;
            if (!have_min_q || cmp_lt) begin
              have_min_q <= 1'b1;
              min_rank_q <= rd_entry_q.rank;
              weak_q     <= keep_q[IW-1:0];
              weak_tag_q <= rd_entry_q.tag;
            end
          end
          if ((rd_cnt_q >= cnt_q) && !rd_vld_q) begin
            cnt_q   <= keep_q;
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (out_free) begin
            accepted_q      <= (limit == '0) || dec_append || dec_steal;
            evicted_q       <= dec_steal;
            evicted_id_q    <= dec_steal ? weak_tag_q : '0;
            voices_active_q <= dec_append ? LimW'(cnt_q + 1'b1) : LimW'(cnt_q);
            if (dec_append) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign evicted_o       = evicted_q;
  assign evicted_id_o    = evicted_id_q;
  assign voices_active_o = voices_active_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_VOICES))
    else $error("voice count exceeds memory depth");

  a_keep_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (keep_q <= rd_cnt_q))
    else $error("compaction write pointer passed the read pointer");

  a_result_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
    else $error("verdict produced outside the decision cycle");

  a_evict_implies_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evicted_q) |-> accepted_q)
    else $error("eviction reported for a rejected note");

  a_evict_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !evicted_q) |-> (evicted_id_q == '0))
    else $error("evicted tag set without an eviction");

endmodule
